>>> design/bmm_pkg.sv
// shared types, constants and helper functions of the boolean matrix multiplier
`timescale 1ns / 1ps

package bmm_pkg;

    localparam int MAX_N   = 64;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int ADDR_W  = $clog2(MAX_N);
    localparam int CNT_W   = $clog2(MAX_N + 1);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SIZE_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_ISSUE
    } state_t;

    // one product row travelling down the chain
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [IDX_W-1:0]  row;
        logic [MAX_N-1:0]  sel;
        logic [DATA_W-1:0] acc;
    } flow_t;

    // chain control from the top level to the sequencer
    typedef struct packed {
        logic advance;
        logic retire;
    } chain_ctl_t;

    function automatic logic [SIZE_W-1:0] eff_n(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] n;
        n = s;
        if (s == '0)
        begin
            n = SIZE_W'(1);
        end
        else if (s > SIZE_W'(MAX_N))
        begin
            n = SIZE_W'(MAX_N);
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] col_mask(input logic [SIZE_W-1:0] n);
        logic [DATA_W-1:0] m;
        for (int k = 0; k < DATA_W; k++)
        begin
            m[k] = (SIZE_W'(k) < n);
        end
        return m;
    endfunction

    function automatic logic row_in_range(input logic [IDX_W-1:0] idx);
        return ({1'b0, idx} < SIZE_W'(MAX_N));
    endfunction

endpackage

>>> design/bmm_cell.sv
// one chain cell: holds one row of B and folds it into the passing product row
`timescale 1ns / 1ps

module bmm_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       b_we,
    input  logic [bmm_pkg::DATA_W-1:0] b_data,
    input  bmm_pkg::flow_t             flow_in,
    output bmm_pkg::flow_t             flow_out
);

    logic [bmm_pkg::DATA_W-1:0] b_reg;
    bmm_pkg::flow_t             flow_reg;
    bmm_pkg::flow_t             flow_next;

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_reg <= b_data;
        end
    end

    // this cell owns bit 0 of sel, the rest moves down for the next cell
    always_comb
    begin
        flow_next      = flow_in;
        flow_next.sel  = flow_in.sel >> 1;
        flow_next.acc  = flow_in.acc | ({bmm_pkg::DATA_W{flow_in.sel[0]}} & b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg <= '0;
        end
        else if (advance)
        begin
            flow_reg <= flow_next;
        end
    end

    assign flow_out = flow_reg;

endmodule

>>> design/bmm_seq.sv
// row sequencer: A row memory, compute state machine and chain head stage
`timescale 1ns / 1ps

module bmm_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_fire,
    input  bmm_pkg::cmd_t              cmd,
    input  logic [bmm_pkg::IDX_W-1:0]  row_index,
    input  logic [bmm_pkg::DATA_W-1:0] row_bits,
    input  logic [bmm_pkg::SIZE_W-1:0] size_in_use,
    input  bmm_pkg::chain_ctl_t        ctl,
    output bmm_pkg::flow_t             head,
    output logic [bmm_pkg::DATA_W-1:0] mask,
    output logic                       idle
);

    logic [bmm_pkg::DATA_W-1:0] a_mem [bmm_pkg::MAX_N];

    bmm_pkg::state_t             state_reg, state_next;
    logic [bmm_pkg::ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [bmm_pkg::CNT_W-1:0]   inflight_reg, inflight_next;
    logic [bmm_pkg::SIZE_W-1:0]  n_reg, n_next;
    logic [bmm_pkg::DATA_W-1:0]  mask_reg, mask_next;
    logic                        rd_vld_reg, rd_last_reg;
    logic [bmm_pkg::IDX_W-1:0]   rd_row_reg;
    logic [bmm_pkg::DATA_W-1:0]  rd_data_reg;

    logic a_we;
    logic start;
    logic issue;
    logic is_last;

    assign a_we  = in_fire && (cmd == bmm_pkg::CMD_LOAD_A)
                   && bmm_pkg::row_in_range(row_index);
    assign start = in_fire && (cmd == bmm_pkg::CMD_COMPUTE);
    assign issue = (state_reg == bmm_pkg::ST_ISSUE) && ctl.advance;
    assign is_last = (bmm_pkg::SIZE_W'(cnt_reg) == (n_reg - bmm_pkg::SIZE_W'(1)));

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[row_index[bmm_pkg::ADDR_W-1:0]] <= row_bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            rd_data_reg <= a_mem[cnt_reg];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        mask_next     = mask_reg;
        case (state_reg)
            bmm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = bmm_pkg::ST_ISSUE;
                    cnt_next   = '0;
                    n_next     = bmm_pkg::eff_n(size_in_use);
                    mask_next  = bmm_pkg::col_mask(bmm_pkg::eff_n(size_in_use));
                end
            end
            bmm_pkg::ST_ISSUE:
            begin
                if (ctl.advance)
                begin
                    cnt_next = cnt_reg + bmm_pkg::ADDR_W'(1);
                    if (is_last)
                    begin
                        state_next = bmm_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bmm_pkg::ST_IDLE;
            end
        endcase
        // rows issued but not yet in the output register
        inflight_next = inflight_reg + bmm_pkg::CNT_W'(issue)
                        - bmm_pkg::CNT_W'(ctl.retire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bmm_pkg::ST_IDLE;
            cnt_reg      <= '0;
            inflight_reg <= '0;
            n_reg        <= '0;
            mask_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            rd_row_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            inflight_reg <= inflight_next;
            n_reg        <= n_next;
            mask_reg     <= mask_next;
            if (ctl.advance)
            begin
                rd_vld_reg  <= issue;
                rd_last_reg <= is_last;
                rd_row_reg  <= bmm_pkg::IDX_W'(cnt_reg);
            end
        end
    end

    always_comb
    begin
        head.vld  = rd_vld_reg;
        head.last = rd_last_reg;
        head.row  = rd_row_reg;
        head.sel  = rd_data_reg[bmm_pkg::MAX_N-1:0] & mask_reg[bmm_pkg::MAX_N-1:0];
        head.acc  = '0;
    end

    assign mask = mask_reg;
    assign idle = (state_reg == bmm_pkg::ST_IDLE) && (inflight_reg == '0);

endmodule

>>> design/boolean_matrix_multiply.sv
// top level of the boolean matrix multiplier: cell chain, output register, apb port
`timescale 1ns / 1ps

// Boolean (OR-AND) matrix product C = A x B for square bit matrices up to 64 by 64.
// A load transaction (cmd 0 for A, cmd 1 for B) gives no result;
// rows of A go to a 64-entry memory, each row of B to its own cell of a 64-cell chain.
// A compute transaction (cmd 2) reads A one row per cycle while the chain advances
// and sends it down the chain, where cell j ORs in B[j] when bit j of the row is set,
// so product rows leave at one per cycle when out_ready stays high. Each row passes
// the memory read stage, the 64 cells and the output register. A new transaction is
// taken once every row of a compute has reached the output register. size_in_use
// sits at apb address 0 (reset 64; 0 acts as 1, above 64 as 64) and may only be
// written while no compute is in flight.
module boolean_matrix_multiply (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmm_pkg::PADDR_W-1:0] paddr,
    input  logic [bmm_pkg::PDATA_W-1:0] pwdata,
    output logic [bmm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [bmm_pkg::IDX_W-1:0]   row_index,
    input  logic [bmm_pkg::DATA_W-1:0]  row_bits,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bmm_pkg::IDX_W-1:0]   out_row,
    output logic [bmm_pkg::DATA_W-1:0]  out_bits,
    output logic                        last
);

    logic [bmm_pkg::SIZE_W-1:0] size_reg;
    logic                       cfg_we;

    logic                       in_fire;
    bmm_pkg::cmd_t              cmd_in;
    logic                       b_load;
    bmm_pkg::chain_ctl_t        ctl;
    bmm_pkg::flow_t             chain [bmm_pkg::MAX_N + 1];
    logic [bmm_pkg::DATA_W-1:0] mask;
    logic                       idle;

    logic                       out_valid_reg;
    logic [bmm_pkg::IDX_W-1:0]  out_row_reg;
    logic [bmm_pkg::DATA_W-1:0] out_bits_reg;
    logic                       last_reg;

    // apb register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == bmm_pkg::REG_SIZE_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= bmm_pkg::SIZE_W'(bmm_pkg::MAX_N);
        end
        else if (cfg_we)
        begin
            size_reg <= pwdata[bmm_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == bmm_pkg::REG_SIZE_IN_USE)
                    ? bmm_pkg::PDATA_W'(size_reg) : '0;

    // input side
    assign in_ready = idle;
    assign in_fire  = in_valid && in_ready;
    assign cmd_in   = bmm_pkg::cmd_t'(cmd);
    assign b_load   = in_fire && (cmd_in == bmm_pkg::CMD_LOAD_B)
                      && bmm_pkg::row_in_range(row_index);

    // whole chain moves only when the output register can take its tail
    assign ctl.advance = !out_valid_reg || out_ready;
    assign ctl.retire  = ctl.advance && chain[bmm_pkg::MAX_N].vld;

    bmm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .cmd         (cmd_in),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .size_in_use (size_reg),
        .ctl         (ctl),
        .head        (chain[0]),
        .mask        (mask),
        .idle        (idle)
    );

    for (genvar j = 0; j < bmm_pkg::MAX_N; j++)
    begin : g_cell
        bmm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (ctl.advance),
            .b_we     (b_load && (row_index[bmm_pkg::ADDR_W-1:0] == bmm_pkg::ADDR_W'(j))),
            .b_data   (row_bits),
            .flow_in  (chain[j]),
            .flow_out (chain[j+1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_bits_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else if (ctl.advance)
        begin
            out_valid_reg <= chain[bmm_pkg::MAX_N].vld;
            if (chain[bmm_pkg::MAX_N].vld)
            begin
                out_row_reg  <= chain[bmm_pkg::MAX_N].row;
                out_bits_reg <= chain[bmm_pkg::MAX_N].acc & mask;
                last_reg     <= chain[bmm_pkg::MAX_N].last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_bits  = out_bits_reg;
    assign last      = last_reg;

endmodule

>>> design/bmm_checker.sv
// port-level checker for the boolean matrix multiplier, bound to the top level
`timescale 1ns / 1ps

module bmm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmm_pkg::PADDR_W-1:0] paddr,
    input  logic [bmm_pkg::PDATA_W-1:0] pwdata,
    input  logic [bmm_pkg::PDATA_W-1:0] prdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [bmm_pkg::IDX_W-1:0]   out_row,
    input  logic [bmm_pkg::DATA_W-1:0]  out_bits,
    input  logic                        last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bits)
                                    && $stable(out_row) && $stable(last))
        else $error("stalled result changed");

    // a compute transaction closes the input until its rows are out
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == bmm_pkg::CMD_COMPUTE) |=> !in_ready)
        else $error("input open right after compute");

    // rows after a non-final one are still in flight
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input open during a compute run");

    // size register reads back what was written
    a_size_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready
         && (paddr[2] == bmm_pkg::REG_SIZE_IN_USE))
        ##1 (paddr[2] == bmm_pkg::REG_SIZE_IN_USE)
        |-> prdata == bmm_pkg::PDATA_W'($past(pwdata[bmm_pkg::SIZE_W-1:0])))
        else $error("size register readback mismatch");

endmodule

bind boolean_matrix_multiply bmm_checker u_bmm_checker (.*);

>>> tb/boolean_matrix_multiply_tb.sv
// self-checking testbench for the boolean matrix multiplier: stimulus, product predictor, checks
`timescale 1ns / 1ps
module boolean_matrix_multiply_tb;

    localparam logic [bmm_pkg::PADDR_W-1:0] ADDR_SIZE_IN_USE = bmm_pkg::PADDR_W'(0);
    localparam logic [bmm_pkg::PADDR_W-1:0] ADDR_UNMAPPED    = bmm_pkg::PADDR_W'(4);
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_GUARD   = 50000;
    localparam logic [bmm_pkg::DATA_W-1:0] ALL_ONES = {bmm_pkg::DATA_W{1'b1}};

    typedef struct packed {
        logic [bmm_pkg::IDX_W-1:0]  row;
        logic [bmm_pkg::DATA_W-1:0] bits;
        logic                       last;
    } prod_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [bmm_pkg::PADDR_W-1:0]   paddr     = '0;
    logic [bmm_pkg::PDATA_W-1:0]   pwdata    = '0;
    logic [bmm_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [1:0]                    cmd       = '0;
    logic [bmm_pkg::IDX_W-1:0]     row_index = '0;
    logic [bmm_pkg::DATA_W-1:0]    row_bits  = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [bmm_pkg::IDX_W-1:0]     out_row;
    logic [bmm_pkg::DATA_W-1:0]    out_bits;
    logic                          last;

    // predictor state
    logic [bmm_pkg::DATA_W-1:0] a_model [bmm_pkg::MAX_N];
    logic [bmm_pkg::DATA_W-1:0] b_model [bmm_pkg::MAX_N];
    bit                         a_loaded [bmm_pkg::MAX_N];
    bit                         b_loaded [bmm_pkg::MAX_N];
    logic [bmm_pkg::SIZE_W-1:0] size_model = bmm_pkg::SIZE_W'(bmm_pkg::MAX_N);
    prod_row_t                  rows_due [$];
    prod_row_t                  row_head;

    bit idle_en      = 1'b1;
    int hold_req     = 0;
    int err_count    = 0;
    int item_count   = 0;
    int compute_count = 0;
    int rows_checked = 0;
    int stall_cycles = 0;

    boolean_matrix_multiply u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .row_index (row_index),
        .row_bits  (row_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .out_bits  (out_bits),
        .last      (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("timeout with %0d product rows outstanding", rows_due.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    function automatic int active_dim();
        int n;
        n = int'(size_model);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > bmm_pkg::MAX_N)
        begin
            n = bmm_pkg::MAX_N;
        end
        return n;
    endfunction

    function automatic logic [bmm_pkg::DATA_W-1:0] dim_mask(input int n);
        if (n >= bmm_pkg::DATA_W)
        begin
            return ALL_ONES;
        end
        return (bmm_pkg::DATA_W'(1) << n) - bmm_pkg::DATA_W'(1);
    endfunction

    // queue the n product rows that one compute transaction must emit
    function automatic void predict_product();
        int n;
        logic [bmm_pkg::DATA_W-1:0] m;
        logic [bmm_pkg::DATA_W-1:0] sel;
        logic [bmm_pkg::DATA_W-1:0] acc;
        prod_row_t r;
        n = active_dim();
        m = dim_mask(n);
        for (int i = 0; i < n; i++)
        begin
            sel = a_model[i] & m;
            acc = '0;
            for (int j = 0; j < n; j++)
            begin
                if (sel[j])
                begin
                    acc |= b_model[j];
                end
            end
            r.row  = bmm_pkg::IDX_W'(i);
            r.bits = acc & m;
            r.last = (i == n - 1);
            rows_due.push_back(r);
        end
        compute_count++;
    endfunction

    function automatic void apply_item(input bmm_pkg::cmd_t c,
                                       input logic [bmm_pkg::IDX_W-1:0] idx,
                                       input logic [bmm_pkg::DATA_W-1:0] bits);
        case (c)
            bmm_pkg::CMD_LOAD_A:
            begin
                a_model[idx]  = bits;
                a_loaded[idx] = 1'b1;
            end
            bmm_pkg::CMD_LOAD_B:
            begin
                b_model[idx]  = bits;
                b_loaded[idx] = 1'b1;
            end
            bmm_pkg::CMD_COMPUTE: predict_product();
            default: ;
        endcase
    endfunction

    function automatic logic [bmm_pkg::DATA_W-1:0] rand_row();
        logic [bmm_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = bmm_pkg::DATA_W'(1) << $urandom_range(0, bmm_pkg::DATA_W - 1);
            3, 4: v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [bmm_pkg::IDX_W-1:0] rand_idx();
        if ($urandom_range(0, 4) != 0)
        begin
            return bmm_pkg::IDX_W'($urandom_range(0, active_dim() - 1));
        end
        return bmm_pkg::IDX_W'($urandom_range(0, bmm_pkg::MAX_N - 1));
    endfunction

    task automatic send_item(input bmm_pkg::cmd_t c,
                             input logic [bmm_pkg::IDX_W-1:0] idx,
                             input logic [bmm_pkg::DATA_W-1:0] bits);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        row_index <= idx;
        row_bits  <= bits;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        apply_item(c, idx, bits);
        if (c != bmm_pkg::CMD_NONE)
        begin
            item_count++;
        end
    endtask

    // drop valid, wait for every queued product row, then let the pipeline empty
    task automatic settle(input int extra);
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_due.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (rows_due.size() != 0)
        begin
            flag_error($sformatf("%0d product rows never arrived", rows_due.size()));
            rows_due.delete();
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic apb_write(input logic [bmm_pkg::PADDR_W-1:0] addr,
                             input logic [bmm_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SIZE_IN_USE)
        begin
            size_model = data[bmm_pkg::SIZE_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic check_size_reg();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SIZE_IN_USE;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata[bmm_pkg::SIZE_W-1:0] !== size_model)
        begin
            flag_error($sformatf("size_in_use read back %0d, expected %0d",
                                 prdata[bmm_pkg::SIZE_W-1:0], size_model));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure_size(input logic [bmm_pkg::PDATA_W-1:0] data);
        settle(SETTLE_CYCLES);
        apb_write(ADDR_SIZE_IN_USE, data);
        check_size_reg();
    endtask

    // rows below n must be loaded before a compute may read them
    task automatic load_missing_rows();
        int n;
        n = active_dim();
        for (int i = 0; i < n; i++)
        begin
            if (!a_loaded[i])
            begin
                send_item(bmm_pkg::CMD_LOAD_A, bmm_pkg::IDX_W'(i), rand_row());
            end
            if (!b_loaded[i])
            begin
                send_item(bmm_pkg::CMD_LOAD_B, bmm_pkg::IDX_W'(i), rand_row());
            end
        end
    endtask

    task automatic send_compute();
        load_missing_rows();
        send_item(bmm_pkg::CMD_COMPUTE, bmm_pkg::IDX_W'($urandom), {$urandom, $urandom});
    endtask

    // output side: random stalls, plus a long hold when a test asks for one
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
                out_ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_ready)
        begin
            stall_cycles++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (rows_due.size() == 0)
            begin
                flag_error($sformatf("unexpected product row %0d bits %h last %b",
                                     out_row, out_bits, last));
            end
            else
            begin
                row_head = rows_due.pop_front();
                rows_checked++;
                if (out_row !== row_head.row || out_bits !== row_head.bits ||
                    last !== row_head.last)
                begin
                    flag_error($sformatf(
                        "row %0d bits %h last %b, expected row %0d bits %h last %b",
                        out_row, out_bits, last,
                        row_head.row, row_head.bits, row_head.last));
                end
            end
        end
    end

    task automatic test_register_access();
        check_size_reg();
        configure_size(32'd0);
        configure_size(32'd127);
        configure_size(32'hFFFF_FF81);
        apb_write(ADDR_UNMAPPED, $urandom);
        check_size_reg();
        configure_size(32'd64);
    endtask

    task automatic test_directed_products();
        // size 0 acts as a 1 by 1 product
        configure_size(32'd0);
        send_item(bmm_pkg::CMD_LOAD_A, bmm_pkg::IDX_W'(0), ALL_ONES);
        send_item(bmm_pkg::CMD_LOAD_B, bmm_pkg::IDX_W'(0), ALL_ONES);
        send_item(bmm_pkg::CMD_COMPUTE, bmm_pkg::IDX_W'(0), '0);
        send_item(bmm_pkg::CMD_LOAD_B, bmm_pkg::IDX_W'(0), '0);
        send_item(bmm_pkg::CMD_COMPUTE, bmm_pkg::IDX_W'(63), ALL_ONES);
        // 4 by 4 with stored bits beyond the used columns
        configure_size(32'd4);
        send_item(bmm_pkg::CMD_LOAD_A, bmm_pkg::IDX_W'(0), 64'hF000_0000_0000_0005);
        send_item(bmm_pkg::CMD_LOAD_A, bmm_pkg::IDX_W'(1), '0);
        send_item(bmm_pkg::CMD_LOAD_A, bmm_pkg::IDX_W'(2), ALL_ONES);
        send_item(bmm_pkg::CMD_LOAD_A, bmm_pkg::IDX_W'(3), 64'h0000_0000_0000_0008);
        send_item(bmm_pkg::CMD_LOAD_B, bmm_pkg::IDX_W'(0), ALL_ONES);
        send_item(bmm_pkg::CMD_LOAD_B, bmm_pkg::IDX_W'(1), 64'h0000_0000_0000_0001);
        send_item(bmm_pkg::CMD_LOAD_B, bmm_pkg::IDX_W'(2), 64'h0000_0000_0000_0002);
        send_item(bmm_pkg::CMD_LOAD_B, bmm_pkg::IDX_W'(3), 64'h8000_0000_0000_0004);
        send_item(bmm_pkg::CMD_LOAD_A, bmm_pkg::IDX_W'(63), ALL_ONES);
        // unused command must leave row 0 alone
        send_item(bmm_pkg::CMD_NONE, bmm_pkg::IDX_W'(0), ALL_ONES);
        send_item(bmm_pkg::CMD_COMPUTE, bmm_pkg::IDX_W'(0), '0);
    endtask

    task automatic test_random_traffic(input int target);
        int sz;
        int len;
        int pick;
        logic [bmm_pkg::PDATA_W-1:0] data;
        while (item_count < target)
        begin
            case ($urandom_range(0, 11))
                0: sz = 0;
                1: sz = 1;
                2: sz = bmm_pkg::MAX_N;
                3: sz = 127;
                4: sz = $urandom_range(bmm_pkg::MAX_N + 1, 126);
                5: sz = $urandom_range(25, bmm_pkg::MAX_N - 1);
                default: sz = $urandom_range(2, 24);
            endcase
            data = $urandom;
            data[bmm_pkg::SIZE_W-1:0] = bmm_pkg::SIZE_W'(sz);
            configure_size(data);
            idle_en = ($urandom_range(0, 3) != 0);
            len = $urandom_range(15, 40);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    send_compute();
                end
                else if (pick < 15)
                begin
                    send_item(bmm_pkg::CMD_NONE, bmm_pkg::IDX_W'($urandom), rand_row());
                end
                else
                begin
                    send_item((pick < 57) ? bmm_pkg::CMD_LOAD_A : bmm_pkg::CMD_LOAD_B,
                              rand_idx(), rand_row());
                end
            end
            send_compute();
        end
        idle_en = 1'b1;
    endtask

    // hold the output long enough that the block backs up and stalls its input
    task automatic test_output_backpressure();
        configure_size(32'd24);
        load_missing_rows();
        idle_en = 1'b0;
        hold_req = 400;
        repeat (4)
        begin
            send_compute();
            send_item(bmm_pkg::CMD_LOAD_B, rand_idx(), rand_row());
        end
        settle(SETTLE_CYCLES);
        idle_en = 1'b1;
    endtask

    task automatic test_steady_stream();
        logic [bmm_pkg::PDATA_W-1:0] data;
        data = $urandom;
        data[bmm_pkg::SIZE_W-1:0] = bmm_pkg::SIZE_W'($urandom_range(1, bmm_pkg::MAX_N));
        configure_size(data);
        idle_en = 1'b0;
        repeat (30)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_compute();
            end
            else
            begin
                send_item($urandom_range(0, 1) ? bmm_pkg::CMD_LOAD_A : bmm_pkg::CMD_LOAD_B,
                          rand_idx(), rand_row());
            end
        end
        send_compute();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_products();
        test_random_traffic(340);
        test_output_backpressure();
        test_steady_stream();
        settle(SETTLE_CYCLES);
        $display("%0d load and compute transactions, %0d products, %0d product rows checked",
                 item_count, compute_count, rows_checked);
        $display("sizes 1 to 64 plus out-of-range settings; input held off for %0d cycles",
                 stall_cycles);
        if (err_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("%0d mismatches", err_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
